[rtl/sfir_pkg.sv]
// Shared types and constants for the stereo FIR filter.
// Used by the front end, the MAC engine, the result queue and the top level.
package sfir_pkg;

    // Opcode field values of an input word.
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_LOAD   = 1'b1;

    // Only tap indexes below this can be addressed by a load word.
    localparam int COEF_SLOTS = 256;

    // Depth of the command queue and of the result queue.
    localparam int Q_DEPTH = 2;

    typedef enum logic {
        CMD_SAMPLE,
        CMD_LOAD
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind   kind;
        logic        channel;
        logic [15:0] data;
        logic [7:0]  tap;
    } t_cmd;

    typedef struct packed {
        logic        channel;
        logic [31:0] filtered;
    } t_result;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_PUSH
    } t_back_state;

endpackage

[rtl/sfir_front.sv]
// Front end of the stereo FIR filter: takes input words, classifies them
// and holds them in a two-entry command queue. Depends on sfir_pkg.
module sfir_front
    import sfir_pkg::*;
#(
    parameter int TAPS     = 256,
    parameter int CHANNELS = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic        i_opcode,
    input  logic        i_channel,
    input  logic [15:0] i_sample,
    input  logic [7:0]  i_tap_index,
    input  logic [15:0] i_coef_value,
    output logic        o_cmd_valid,
    output t_cmd        o_cmd,
    input  logic        i_cmd_take
);

    t_cmd       r_q [Q_DEPTH];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_cnt;

    t_cmd cmd_new;
    logic keep;
    logic enq;
    logic deq;

    always_comb begin
        cmd_new = '0;
        keep    = 1'b1;
        unique case (i_opcode)
            OP_LOAD: begin
                cmd_new.kind = CMD_LOAD;
                cmd_new.data = i_coef_value;
                cmd_new.tap  = i_tap_index;
                // A load beyond the coefficient store is dropped here.
                keep = (32'(i_tap_index) < 32'(TAPS));
            end
            default: begin
                cmd_new.kind    = CMD_SAMPLE;
                cmd_new.data    = i_sample;
                cmd_new.channel = (CHANNELS > 1) ? i_channel : 1'b0;
            end
        endcase
    end

    assign full        = (r_cnt == 2'(Q_DEPTH));
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rd_ptr];
    assign enq         = push && !full && keep;
    assign deq         = i_cmd_take && o_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (enq) begin
            r_q[r_wr_ptr] <= cmd_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (enq) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (deq) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_cnt <= r_cnt + 2'(enq) - 2'(deq);
        end
    end

endmodule

[rtl/sfir_back.sv]
// MAC engine of the stereo FIR filter: coefficient store, delay line memory
// and a three-stage multiply-accumulate pipeline. Depends on sfir_pkg.
module sfir_back
    import sfir_pkg::*;
#(
    parameter int TAPS     = 256,
    parameter int CHANNELS = 2
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_cmd_valid,
    input  t_cmd    i_cmd,
    output logic    o_cmd_take,
    output logic    o_res_push,
    output t_result o_res,
    input  logic    i_res_full
);

    localparam int TW  = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int FW  = $clog2(TAPS + 1);
    localparam int CS  = (TAPS < COEF_SLOTS) ? TAPS : COEF_SLOTS;
    localparam int CSW = (CS > 1) ? $clog2(CS) : 1;
    localparam int DD  = CHANNELS * TAPS;
    localparam int AW  = (DD > 1) ? $clog2(DD) : 1;
    localparam int CW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Memories: one delay line row per channel, one shared coefficient row.
    logic [15:0] r_dmem [DD];
    logic [15:0] r_cmem [CS];
    logic [CS-1:0] r_cvalid;

    t_back_state r_state, n_state;
    logic [TW-1:0] r_k;
    logic [TW-1:0] r_rp;
    logic [TW-1:0] r_wp   [CHANNELS];
    logic [FW-1:0] r_fill [CHANNELS];
    logic [FW-1:0] r_fill_cur;
    logic          r_ch;

    logic        r_s1_vld, r_s1_last, r_s1_sok, r_s1_cok;
    logic [15:0] r_s1_samp, r_s1_coef;
    logic        r_s2_vld, r_s2_last;
    logic signed [31:0] r_s2_prod;
    logic signed [31:0] r_acc;

    logic          take_sample;
    logic          take_load;
    logic          issue;
    logic          mac_last;
    logic [CW-1:0] cmd_ch;
    logic [TW-1:0] wp_cur;
    logic [FW-1:0] fill_next;
    logic [AW-1:0] waddr;
    logic [AW-1:0] raddr;
    logic [CSW-1:0] caddr;
    logic          k_in_coef;
    logic signed [15:0] samp_eff, coef_eff;

    always_comb begin
        n_state    = r_state;
        o_cmd_take = 1'b0;
        o_res_push = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_take = 1'b1;
                    if (i_cmd.kind == CMD_SAMPLE) begin
                        n_state = ST_MAC;
                    end
                end
            end
            ST_MAC: begin
                if (mac_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (r_s2_vld && r_s2_last) begin
                    n_state = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign take_sample = o_cmd_take && (i_cmd.kind == CMD_SAMPLE);
    assign take_load   = o_cmd_take && (i_cmd.kind == CMD_LOAD);
    assign issue       = (r_state == ST_MAC);
    assign mac_last    = (r_k == TW'(TAPS - 1));

    assign cmd_ch    = CW'(i_cmd.channel);
    assign wp_cur    = r_wp[cmd_ch];
    assign fill_next = (r_fill[cmd_ch] == FW'(TAPS)) ? r_fill[cmd_ch]
                                                     : r_fill[cmd_ch] + 1'b1;

    assign waddr = (i_cmd.channel ? AW'(TAPS) : AW'(0)) + AW'(wp_cur);
    assign raddr = (r_ch ? AW'(TAPS) : AW'(0)) + AW'(r_rp);

    // Taps from the coefficient store limit up are never loaded and read zero.
    assign caddr     = r_k[CSW-1:0];
    assign k_in_coef = (FW'(r_k) < FW'(CS));

    assign samp_eff = r_s1_sok ? $signed(r_s1_samp) : 16'sd0;
    assign coef_eff = r_s1_cok ? $signed(r_s1_coef) : 16'sd0;

    assign o_res.channel  = r_ch;
    assign o_res.filtered = r_acc;

    always_ff @(posedge i_clk) begin
        if (take_sample) begin
            r_dmem[waddr] <= i_cmd.data;
        end
        if (take_load) begin
            r_cmem[i_cmd.tap[CSW-1:0]] <= i_cmd.data;
        end
    end

    // Stage one: registered memory reads; stage two: product.
    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_s1_samp <= r_dmem[raddr];
            r_s1_coef <= r_cmem[caddr];
            r_s1_sok  <= (FW'(r_k) < r_fill_cur);
            r_s1_cok  <= k_in_coef && r_cvalid[caddr];
        end
        r_s2_prod <= samp_eff * coef_eff;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_k        <= '0;
            r_rp       <= '0;
            r_fill_cur <= '0;
            r_ch       <= 1'b0;
            r_cvalid   <= '0;
            r_s1_vld   <= 1'b0;
            r_s1_last  <= 1'b0;
            r_s2_vld   <= 1'b0;
            r_s2_last  <= 1'b0;
            r_acc      <= '0;
            for (int c = 0; c < CHANNELS; c++) begin
                r_wp[c]   <= '0;
                r_fill[c] <= '0;
            end
        end else begin
            r_state   <= n_state;
            r_s1_vld  <= issue;
            r_s1_last <= issue && mac_last;
            r_s2_vld  <= r_s1_vld;
            r_s2_last <= r_s1_last;
            if (take_load) begin
                r_cvalid[i_cmd.tap[CSW-1:0]] <= 1'b1;
            end
            if (take_sample) begin
                r_ch           <= i_cmd.channel;
                r_rp           <= wp_cur;
                r_k            <= '0;
                r_acc          <= '0;
                r_fill_cur     <= fill_next;
                r_fill[cmd_ch] <= fill_next;
                r_wp[cmd_ch]   <= (wp_cur == TW'(TAPS - 1)) ? '0 : wp_cur + 1'b1;
            end
            if (issue) begin
                r_k  <= r_k + 1'b1;
                // Walk the delay line backward from the newest sample.
                r_rp <= (r_rp == '0) ? TW'(TAPS - 1) : r_rp - 1'b1;
            end
            if (r_s2_vld) begin
                r_acc <= r_acc + (r_s2_prod >>> 15);
            end
        end
    end

`ifndef SYNTHESIS
    a_idle_pipe_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (!r_s1_vld && !r_s2_vld))
        else $error("MAC pipeline busy while engine is idle");

    a_sample_starts_mac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take_sample |=> (r_state == ST_MAC) && (r_k == '0))
        else $error("sample word did not start the MAC loop at tap zero");

    a_push_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == ST_PUSH) |-> $past(r_s2_vld && r_s2_last))
        else $error("result ready before the last tap was accumulated");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill[0] <= FW'(TAPS))
        else $error("fill count exceeds tap count");
`endif

endmodule

[rtl/sfir_res_q.sv]
// Two-entry result queue of the stereo FIR filter, between the MAC engine
// and the output ports. Depends on sfir_pkg.
module sfir_res_q
    import sfir_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_res,
    output logic    o_full,
    output logic    empty,
    input  logic    pop,
    output t_result o_res
);

    t_result    r_q [Q_DEPTH];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_cnt;

    logic enq;
    logic deq;

    assign o_full = (r_cnt == 2'(Q_DEPTH));
    assign empty  = (r_cnt == 2'd0);
    assign o_res  = r_q[r_rd_ptr];
    assign enq    = i_push && !o_full;
    assign deq    = pop && !empty;

    always_ff @(posedge i_clk) begin
        if (enq) begin
            r_q[r_wr_ptr] <= i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (enq) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (deq) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_cnt <= r_cnt + 2'(enq) - 2'(deq);
        end
    end

endmodule

[rtl/stereo_fir_filter.sv]
// Stereo FIR filter top level: front end, MAC engine and result queue.
// A sample word is taken only while the MAC engine is idle, so one sample is
// finished before the next starts; its taps are walked in turn by the single
// multiply-accumulate unit and the single read port of the delay line memory.
// A load word leaves the engine idle. Synchronous active-low reset empties both
// queues and reads all coefficients and delay lines as zero.
module stereo_fir_filter
    import sfir_pkg::*;
#(
    parameter int TAPS     = 256,
    parameter int CHANNELS = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic        i_opcode,
    input  logic        i_channel,
    input  logic [15:0] i_sample,
    input  logic [7:0]  i_tap_index,
    input  logic [15:0] i_coef_value,
    output logic        empty,
    input  logic        pop,
    output logic        o_out_channel,
    output logic [31:0] o_filtered
);

    logic    cmd_valid;
    t_cmd    cmd;
    logic    cmd_take;
    logic    res_push;
    logic    res_full;
    t_result res_in;
    t_result res_out;

    sfir_front #(
        .TAPS     (TAPS),
        .CHANNELS (CHANNELS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_opcode     (i_opcode),
        .i_channel    (i_channel),
        .i_sample     (i_sample),
        .i_tap_index  (i_tap_index),
        .i_coef_value (i_coef_value),
        .o_cmd_valid  (cmd_valid),
        .o_cmd        (cmd),
        .i_cmd_take   (cmd_take)
    );

    sfir_back #(
        .TAPS     (TAPS),
        .CHANNELS (CHANNELS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_take  (cmd_take),
        .o_res_push  (res_push),
        .o_res       (res_in),
        .i_res_full  (res_full)
    );

    sfir_res_q u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_res   (res_in),
        .o_full  (res_full),
        .empty   (empty),
        .pop     (pop),
        .o_res   (res_out)
    );

    assign o_out_channel = res_out.channel;
    assign o_filtered    = res_out.filtered;

endmodule
